// ----- rtl/core/blr_pkg.sv -----
// Shared types and constants for the line rasteriser.
// No dependencies; used by blr_front, blr_engine and the top level under rtl/core.
`default_nettype none

package blr_pkg;

  // Field widths
  localparam int XW = 9;
  localparam int YW = 8;
  localparam int CW = 16;

  // Screen limits; endpoints are saturated to these
  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;

  localparam logic [XW-1:0] X_MAX = XW'(SCREEN_WIDTH - 1);
  localparam logic [YW-1:0] Y_MAX = YW'(SCREEN_HEIGHT - 1);

  // Error term and doubled delta widths
  localparam int EW = XW + 2;
  localparam int DW = XW + 1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  // Input item as seen on the ports
  typedef struct packed {
    cmd_t            command;
    logic [XW-1:0]   start_x;
    logic [YW-1:0]   start_y;
    logic [XW-1:0]   end_x;
    logic [YW-1:0]   end_y;
    logic [CW-1:0]   line_color;
  } item_t;

  // Result item as seen on the ports
  typedef struct packed {
    logic [XW-1:0]   pixel_x;
    logic [YW-1:0]   pixel_y;
    logic [CW-1:0]   pixel_color;
    logic            last_pixel;
  } pixel_t;

  // Classified command held in the queue between front and back
  typedef struct packed {
    cmd_t            command;
    logic [XW-1:0]   x0;
    logic [YW-1:0]   y0;
    logic [XW-1:0]   x1;
    logic [YW-1:0]   y1;
    logic [CW-1:0]   color;
    logic [XW-1:0]   adx;
    logic [XW-1:0]   ady;
    logic            x_dec;
    logic            y_dec;
  } cmd_entry_t;

endpackage

`default_nettype wire

// ----- rtl/core/blr_fifo.sv -----
// Two-entry queue of W-bit words, used between front and back and for results.
// Depends on nothing.
`default_nettype none

module blr_fifo #(
  parameter int W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wdata;
  end

endmodule

`default_nettype wire

// ----- rtl/core/blr_front.sv -----
// Front end: saturates endpoints and works out absolute deltas and directions.
// Depends on blr_pkg.
`default_nettype none

module blr_front
  import blr_pkg::*;
(
  input  wire item_t  item,
  output cmd_entry_t  entry
);

  logic [XW-1:0] x0, x1;
  logic [YW-1:0] y0, y1;
  logic          x_dec, y_dec;

  // Keep endpoints on screen
  always_comb begin
    x0 = (item.start_x > X_MAX) ? X_MAX : item.start_x;
    x1 = (item.end_x   > X_MAX) ? X_MAX : item.end_x;
    y0 = (item.start_y > Y_MAX) ? Y_MAX : item.start_y;
    y1 = (item.end_y   > Y_MAX) ? Y_MAX : item.end_y;
  end

  assign x_dec = (x1 < x0);
  assign y_dec = (y1 < y0);

  // Absolute deltas, both subtractions in parallel
  always_comb begin
    entry.command = item.command;
    entry.x0      = x0;
    entry.y0      = y0;
    entry.x1      = x1;
    entry.y1      = y1;
    entry.color   = item.line_color;
    entry.x_dec   = x_dec;
    entry.y_dec   = y_dec;
    entry.adx     = x_dec ? (x0 - x1) : (x1 - x0);
    entry.ady     = y_dec ? XW'(y0 - y1) : XW'(y1 - y0);
  end

endmodule

`default_nettype wire

// ----- rtl/core/blr_engine.sv -----
// Back end: Bresenham stepping state, one command per cycle unless held by a full result queue, pushes pixels.
// Depends on blr_pkg.
`default_nettype none

module blr_engine
  import blr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_entry_t  cmd,
  input  wire logic        cmd_empty,
  output logic             cmd_pop,
  output logic             res_push,
  output pixel_t           res,
  input  wire logic        res_full
);

  logic [XW-1:0] cur_x, target_x, cur_x_next;
  logic [YW-1:0] cur_y, target_y, cur_y_next;
  logic [DW-1:0] twice_dx, twice_dy, tdx_next, tdy_next;
  logic [EW-1:0] error_term, err_next;
  logic          x_decrements, y_decrements, x_is_major, line_active;
  logic [CW-1:0] held_color;
  logic          major_next, last;
  logic          is_start, fire, move_minor;

  assign is_start = (cmd.command == CMD_START);
  // A step while idle is consumed without a result
  assign fire     = !cmd_empty && (!res_full || (!is_start && !line_active));
  assign cmd_pop  = fire;
  assign res_push = fire && (is_start || line_active);

  // Setup values for a start
  assign tdx_next   = {1'b0, cmd.adx} << 1;
  assign tdy_next   = {1'b0, cmd.ady} << 1;
  assign major_next = (cmd.adx > cmd.ady);
  assign move_minor = !error_term[EW-1];

  // Next position, error and last flag; error kept modulo its width
  always_comb begin
    cur_x_next = cur_x;
    cur_y_next = cur_y;
    err_next   = error_term;
    last       = 1'b0;
    if (is_start) begin
      cur_x_next = cmd.x0;
      cur_y_next = cmd.y0;
      if (major_next) begin
        err_next = {1'b0, tdy_next} - {2'b00, cmd.adx};
        last     = (cmd.adx == '0);
      end else begin
        err_next = {1'b0, tdx_next} - {2'b00, cmd.ady};
        last     = (cmd.ady == '0);
      end
    end else if (x_is_major) begin
      if (move_minor) cur_y_next = y_decrements ? cur_y - 1'b1 : cur_y + 1'b1;
      cur_x_next = x_decrements ? cur_x - 1'b1 : cur_x + 1'b1;
      err_next   = error_term - (move_minor ? {1'b0, twice_dx} : '0) + {1'b0, twice_dy};
      last       = (cur_x_next == target_x);
    end else begin
      if (move_minor) cur_x_next = x_decrements ? cur_x - 1'b1 : cur_x + 1'b1;
      cur_y_next = y_decrements ? cur_y - 1'b1 : cur_y + 1'b1;
      err_next   = error_term - (move_minor ? {1'b0, twice_dy} : '0) + {1'b0, twice_dx};
      last       = (cur_y_next == target_y);
    end
  end

  // Result word
  always_comb begin
    res.pixel_x     = cur_x_next;
    res.pixel_y     = cur_y_next;
    res.pixel_color = is_start ? cmd.color : held_color;
    res.last_pixel  = last;
  end

  // Activity flag
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (res_push) begin
      line_active <= !last;
    end
  end

  // Line state
  always_ff @(posedge clk) begin
    if (res_push) begin
      cur_x      <= cur_x_next;
      cur_y      <= cur_y_next;
      error_term <= err_next;
    end
    if (fire && is_start) begin
      target_x     <= cmd.x1;
      target_y     <= cmd.y1;
      twice_dx     <= tdx_next;
      twice_dy     <= tdy_next;
      x_decrements <= cmd.x_dec;
      y_decrements <= cmd.y_dec;
      x_is_major   <= major_next;
      held_color   <= cmd.color;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/bresenham_line_rasterizer.sv -----
// Bresenham line rasteriser: one command in, at most one pixel out, per cycle, unless a queue is full.
// Path: an accepted command is registered in the command queue, goes through the
// combinational engine and is registered in the result queue before its pixel shows (empty low).
// Throughput: one command per cycle while neither queue stalls, set by the combinational error update.
// Reset: synchronous rst empties both queues and leaves the engine idle.
// Depends on blr_pkg, blr_front, blr_fifo, blr_engine.
`default_nettype none

module bresenham_line_rasterizer
  import blr_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   push,
  input  wire item_t  item,
  output logic        full,
  input  wire logic   pop,
  output pixel_t      result,
  output logic        empty
);

  cmd_entry_t in_entry, cmd_head;
  logic       cmd_empty, cmd_pop;
  logic       res_push, res_full;
  pixel_t     res_data;

  // Classify and set up
  blr_front u_front (
    .item  (item),
    .entry (in_entry)
  );

  // Command queue between front and back
  blr_fifo #(.W($bits(cmd_entry_t))) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (in_entry),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_head),
    .empty (cmd_empty)
  );

  // Stepping engine
  blr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_head),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .res_push  (res_push),
    .res       (res_data),
    .res_full  (res_full)
  );

  // Result queue
  blr_fifo #(.W($bits(pixel_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_data),
    .full  (res_full),
    .pop   (pop),
    .rdata (result),
    .empty (empty)
  );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for bresenham_line_rasterizer: a directed table, then random lines.
// Pixels are predicted in-bench and checked as each one is popped.
// Depends on blr_pkg and the rasteriser RTL only.
`default_nettype none

module testbench
  import blr_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int PIXEL_TARGET  = 1800;
  localparam int DRAIN_CYCLES  = 8;
  localparam int IDLE_PERCENT  = 29;

  // One row of the directed table; typed rows carry their own expected pixel
  typedef struct {
    item_t  stim;
    bit     typed;
    bit     yields;
    pixel_t pix;
  } plan_row_t;

  logic   clk  = 1'b0;
  logic   rst  = 1'b1;
  logic   push = 1'b0;
  logic   pop  = 1'b0;
  item_t  item = '0;
  logic   full;
  logic   empty;
  pixel_t result;

  // No idling on either side while this is set
  logic   steady = 1'b0;

  int     cycles = 0;
  int     mismatches = 0;
  int     pixels_drawn = 0;
  pixel_t expected_pixels[$];

  // Shadow of the line engine
  int     pos_x, pos_y, goal_x, goal_y;
  int     dbl_dx, dbl_dy, err;
  bit     dec_x, dec_y, major_x, drawing;
  logic [CW-1:0] colour;

  plan_row_t plan[24];

  bresenham_line_rasterizer uut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .item   (item),
    .full   (full),
    .pop    (pop),
    .result (result),
    .empty  (empty)
  );

  always #2ns clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Next pixel of the shadow engine; returns 0 when the item draws nothing
  function automatic bit predict_pixel(input item_t it, output pixel_t px);
    int dx, dy;
    bit last;
    px = '0;
    if (it.command == CMD_START) begin
      pos_x  = (it.start_x > X_MAX) ? X_MAX : it.start_x;
      pos_y  = (it.start_y > Y_MAX) ? Y_MAX : it.start_y;
      goal_x = (it.end_x > X_MAX) ? X_MAX : it.end_x;
      goal_y = (it.end_y > Y_MAX) ? Y_MAX : it.end_y;
      colour = it.line_color;
      dx = goal_x - pos_x;
      dy = goal_y - pos_y;
      dec_x = dx < 0;
      dec_y = dy < 0;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      dbl_dx = 2 * dx;
      dbl_dy = 2 * dy;
      // ties go to the y axis
      major_x = dbl_dx > dbl_dy;
      if (major_x) begin
        err  = dbl_dy - dx;
        last = pos_x == goal_x;
      end else begin
        err  = dbl_dx - dy;
        last = pos_y == goal_y;
      end
      drawing = !last;
    end else if (!drawing) begin
      return 1'b0;
    end else if (major_x) begin
      if (err >= 0) begin
        pos_y += dec_y ? -1 : 1;
        err   -= dbl_dx;
      end
      pos_x += dec_x ? -1 : 1;
      err   += dbl_dy;
      last = pos_x == goal_x;
      if (last) drawing = 1'b0;
    end else begin
      if (err >= 0) begin
        pos_x += dec_x ? -1 : 1;
        err   -= dbl_dy;
      end
      pos_y += dec_y ? -1 : 1;
      err   += dbl_dx;
      last = pos_y == goal_y;
      if (last) drawing = 1'b0;
    end
    px.pixel_x     = XW'(pos_x);
    px.pixel_y     = YW'(pos_y);
    px.pixel_color = colour;
    px.last_pixel  = last;
    return 1'b1;
  endfunction

  function automatic item_t start_cmd(input int x0, input int y0, input int x1, input int y1,
                                      input logic [CW-1:0] c);
    item_t it;
    it.command    = CMD_START;
    it.start_x    = XW'(x0);
    it.start_y    = YW'(y0);
    it.end_x      = XW'(x1);
    it.end_y      = YW'(y1);
    it.line_color = c;
    return it;
  endfunction

  // Step with random bits in the fields that a step ignores
  function automatic item_t step_cmd();
    logic [$bits(item_t)-1:0] raw;
    item_t it;
    raw = ($bits(item_t))'({$urandom, $urandom});
    it = raw;
    it.command = CMD_STEP;
    return it;
  endfunction

  function automatic pixel_t pix(input int x, input int y, input logic [CW-1:0] c,
                                 input bit last);
    pixel_t p;
    p.pixel_x     = XW'(x);
    p.pixel_y     = YW'(y);
    p.pixel_color = c;
    p.last_pixel  = last;
    return p;
  endfunction

  // Random coordinate within span of base, kept on screen
  function automatic int near(input int base, input int span, input int limit);
    int v;
    v = base + $urandom_range(2 * span) - span;
    if (v < 0) v = 0;
    if (v > limit - 1) v = limit - 1;
    return v;
  endfunction

  // Push one item after a random gap, then log its expected pixel on transfer
  task automatic send(input item_t it, input bit typed = 1'b0, input bit yields = 1'b0,
                      input pixel_t lit = '0);
    pixel_t px;
    bit got;
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    got = predict_pixel(it, px);
    if (typed) begin
      got = yields;
      px  = lit;
    end
    if (got) begin
      expected_pixels.push_back(px);
      pixels_drawn++;
    end
  endtask

  // Result side: check each transfer, then choose pop for the next cycle
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && pop && !empty) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected pixel, expected none, actual %p", $time, result);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (result.pixel_x !== want.pixel_x) begin
          $display("%0t: pixel_x expected %0d actual %0d", $time, want.pixel_x,
                   result.pixel_x);
          mismatches++;
        end
        if (result.pixel_y !== want.pixel_y) begin
          $display("%0t: pixel_y expected %0d actual %0d", $time, want.pixel_y,
                   result.pixel_y);
          mismatches++;
        end
        if (result.pixel_color !== want.pixel_color) begin
          $display("%0t: pixel_color expected %h actual %h", $time, want.pixel_color,
                   result.pixel_color);
          mismatches++;
        end
        if (result.last_pixel !== want.last_pixel) begin
          $display("%0t: last_pixel expected %b actual %b", $time, want.last_pixel,
                   result.last_pixel);
          mismatches++;
        end
      end
    end
    if (rst) begin
      pop <= 1'b0;
    end else begin
      pop <= steady || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  // Stimulus
  initial begin
    int kind, x0, y0, x1, y1;
    bit abandon;

    // directed table: idle steps, zero-length lines, saturation, x-major and y-major lines
    plan[0]  = '{step_cmd(), 1'b1, 1'b0, '0};
    plan[1]  = '{start_cmd(0, 0, 0, 0, 16'hFFFF), 1'b1, 1'b1, pix(0, 0, 16'hFFFF, 1'b1)};
    plan[2]  = '{step_cmd(), 1'b1, 1'b0, '0};
    plan[3]  = '{start_cmd(319, 239, 319, 239, 16'h0000), 1'b1, 1'b1,
                 pix(319, 239, 16'h0000, 1'b1)};
    plan[4]  = '{start_cmd(511, 255, 400, 250, 16'hA5A5), 1'b1, 1'b1,
                 pix(319, 239, 16'hA5A5, 1'b1)};
    plan[5]  = '{start_cmd(0, 0, 3, 1, 16'h1234), 1'b1, 1'b1, pix(0, 0, 16'h1234, 1'b0)};
    plan[6]  = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[7]  = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[8]  = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[9]  = '{step_cmd(), 1'b1, 1'b0, '0};
    plan[10] = '{start_cmd(5, 5, 5, 1, 16'h07E0), 1'b1, 1'b1, pix(5, 5, 16'h07E0, 1'b0)};
    plan[11] = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[12] = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[13] = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[14] = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[15] = '{start_cmd(10, 10, 7, 13, 16'hF800), 1'b1, 1'b1,
                 pix(10, 10, 16'hF800, 1'b0)};
    plan[16] = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[17] = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[18] = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[19] = '{start_cmd(0, 239, 319, 0, 16'h001F), 1'b1, 1'b1,
                 pix(0, 239, 16'h001F, 1'b0)};
    plan[20] = '{step_cmd(), 1'b0, 1'b0, '0};
    // start while a line is still being drawn
    plan[21] = '{start_cmd(319, 0, 0, 239, 16'h8001), 1'b1, 1'b1,
                 pix(319, 0, 16'h8001, 1'b0)};
    plan[22] = '{step_cmd(), 1'b0, 1'b0, '0};
    plan[23] = '{step_cmd(), 1'b0, 1'b0, '0};

    // shadow engine starts idle, as after reset
    pos_x = 0; pos_y = 0; goal_x = 0; goal_y = 0;
    dbl_dx = 0; dbl_dy = 0; err = 0;
    dec_x = 0; dec_y = 0; major_x = 0; drawing = 0; colour = '0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) send(plan[i].stim, plan[i].typed, plan[i].yields, plan[i].pix);

    // Random lines: mostly short ones stepped to the end, some abandoned, some noise
    while (pixels_drawn < PIXEL_TARGET) begin
      steady <= (pixels_drawn >= 700 && pixels_drawn < 1000);
      kind = $urandom_range(99);
      if (kind < 8) begin
        send(step_cmd());
        if ($urandom_range(1)) send(start_cmd($urandom_range(511), $urandom_range(255),
                                              $urandom_range(511), $urandom_range(255),
                                              CW'($urandom_range(16'hFFFF))));
      end else begin
        x0 = $urandom_range(319);
        y0 = $urandom_range(239);
        if (kind < 75) begin
          x1 = near(x0, 12, SCREEN_WIDTH);
          y1 = near(y0, 12, SCREEN_HEIGHT);
        end else if (kind < 92) begin
          x1 = $urandom_range(319);
          y1 = $urandom_range(239);
        end else begin
          // corners and off-screen endpoints
          x0 = $urandom_range(1) ? $urandom_range(511) : ($urandom_range(1) ? 319 : 0);
          y0 = $urandom_range(1) ? $urandom_range(255) : ($urandom_range(1) ? 239 : 0);
          x1 = $urandom_range(1) ? $urandom_range(511) : ($urandom_range(1) ? 319 : 0);
          y1 = $urandom_range(1) ? $urandom_range(255) : ($urandom_range(1) ? 239 : 0);
        end
        send(start_cmd(x0, y0, x1, y1, CW'($urandom_range(16'hFFFF))));
        abandon = 1'b0;
        while (drawing && !abandon) begin
          send(step_cmd());
          abandon = $urandom_range(99) < 2;
        end
        // occasional steps past the end of the line
        if (!drawing && $urandom_range(99) < 15) begin
          repeat ($urandom_range(2, 1)) send(step_cmd());
        end
      end
    end
    steady <= 1'b0;
    push <= 1'b0;

    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire
